// ----- rtl/gamepad_press_time_controller_top_assert.svh -----
// Assertion macros for the gamepad press-time controller.
`ifndef GAMEPAD_PRESS_TIME_CONTROLLER_TOP_ASSERT_SVH
`define GAMEPAD_PRESS_TIME_CONTROLLER_TOP_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define GPTC_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("gptc invariant failed");

// An implication from one cycle to the next.
`define GPTC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gptc next-cycle check failed");

// An implication within the same cycle.
`define GPTC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gptc same-cycle check failed");

`endif

// ----- rtl/gptc_pkg.sv -----
// Package with constants, beat types and helpers of the gamepad press-time controller.
`default_nettype none

package gptc_pkg;

    localparam int PADS       = 4;
    localparam int CONTROLS   = 11;
    localparam int PAD_W      = (PADS > 1) ? $clog2(PADS) : 1;
    localparam int CNT_W      = 13;
    localparam int TIME_LIMIT = 3600;
    localparam int DIRECTIONS = 4;

    localparam logic [2:0] OP_READ    = 3'd0;
    localparam logic [2:0] OP_WRITE   = 3'd1;
    localparam logic [2:0] OP_TICK    = 3'd2;
    localparam logic [2:0] OP_CONNECT = 3'd3;
    localparam logic [2:0] OP_CONTROL = 3'd4;

    localparam logic [3:0] PORT_SELECT    = 4'd0;
    localparam logic [3:0] PORT_CONNECTED = 4'd1;
    localparam logic [3:0] PORT_COUNTERS  = 4'd2;

    typedef logic signed [CNT_W-1:0] cnt_t;

    localparam cnt_t CNT_MAX = cnt_t'(TIME_LIMIT);
    localparam cnt_t CNT_MIN = cnt_t'(-TIME_LIMIT);

    typedef struct packed {
        logic [2:0]         opcode;
        logic [3:0]         port;
        logic signed [31:0] write_value;
        logic [1:0]         pad;
        logic [3:0]         control;
        logic               level;
    } req_t;

    typedef struct packed {
        logic signed [12:0] read_data;
        logic               status;
    } rsp_t;

    // One frame of aging: move away from zero (zero counts as held), then clamp.
    function automatic cnt_t age_count(input cnt_t t);
        cnt_t r;
        if (t < 0)
        begin
            r = (t <= CNT_MIN) ? CNT_MIN : t - cnt_t'(1);
        end
        else
        begin
            r = (t >= CNT_MAX) ? CNT_MAX : t + cnt_t'(1);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/gamepad_press_time_controller_top.sv -----
// Top level of the gamepad press-time controller.
`default_nettype none
`include "gamepad_press_time_controller_top_assert.svh"

// The controller keeps, per pad, a connected flag and a row of signed
// press-time counters in two copies: a live copy that follows connection and
// control events, and a shown copy that bus reads see and that a frame tick
// refreshes. A request beat is captured in an input register; once the
// result register is free or drained, its whole effect is computed by short
// logic that acts on all counter cells in parallel, the state is updated, and
// the response beat is loaded into the result register. Every request gives
// exactly one response. The block takes one request per cycle when the
// response side keeps up. The response valid rises as the item moves from the
// input register into the result register; the only limit is the result
// register, which holds its beat while the response ready is low and then
// stops the input register from advancing. All state is reset to its initial
// values (selection 0, pads disconnected, counters at -3600) directly by
// rst_n, so no clearing pass is needed.
module gamepad_press_time_controller_top
    import gptc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    logic             in_valid_reg;
    req_t             in_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;
    logic             advance;

    logic [PAD_W-1:0] sel_reg;
    logic [PAD_W-1:0] sel_next;
    logic             live_conn_reg  [PADS];
    logic             live_conn_next [PADS];
    logic             shown_conn_reg [PADS];
    logic             shown_conn_next[PADS];
    cnt_t             live_reg  [PADS][CONTROLS];
    cnt_t             live_next [PADS][CONTROLS];
    cnt_t             shown_reg [PADS][CONTROLS];
    cnt_t             shown_next[PADS][CONTROLS];

    // The input register moves on whenever the result register is free or drained.
    assign advance   = in_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready = !in_valid_reg || advance;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            in_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            in_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Response for the item in the input register, read from the current state.
    always_comb
    begin
        logic [3:0] idx;
        idx      = in_reg.port - PORT_COUNTERS;
        rsp_next = '0;
        case (in_reg.opcode)
            OP_READ:
            begin
                if (in_reg.port == PORT_SELECT)
                begin
                    rsp_next.read_data = 13'(sel_reg);
                end
                else if (in_reg.port == PORT_CONNECTED)
                begin
                    rsp_next.read_data = 13'(shown_conn_reg[sel_reg]);
                end
                else if (int'(idx) < CONTROLS)
                begin
                    rsp_next.read_data = shown_reg[sel_reg][idx];
                end
                else
                begin
                    rsp_next.status = 1'b1;
                end
            end
            OP_WRITE:
            begin
                rsp_next.status = (in_reg.port != PORT_SELECT);
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    // Next state: each pad flag and counter cell computes its own update.
    always_comb
    begin
        logic pad_ok;
        logic ctl_ok;
        logic was_held;
        logic take_event;
        logic [3:0] opp;

        pad_ok     = int'(in_reg.pad) < PADS;
        ctl_ok     = int'(in_reg.control) < CONTROLS;
        opp        = in_reg.control ^ 4'd1;
        was_held   = 1'b0;
        take_event = 1'b0;
        if (pad_ok && ctl_ok)
        begin
            was_held   = live_reg[in_reg.pad][in_reg.control] > 0;
            take_event = live_conn_reg[in_reg.pad] && (in_reg.level != was_held);
        end

        sel_next = sel_reg;
        if (in_reg.opcode == OP_WRITE && in_reg.port == PORT_SELECT
            && $unsigned(in_reg.write_value) < 32'(PADS))
        begin
            sel_next = in_reg.write_value[PAD_W-1:0];
        end

        for (int p = 0; p < PADS; p++)
        begin
            live_conn_next[p]  = live_conn_reg[p];
            shown_conn_next[p] = shown_conn_reg[p];
            for (int c = 0; c < CONTROLS; c++)
            begin
                live_next[p][c]  = live_reg[p][c];
                shown_next[p][c] = shown_reg[p][c];
            end

            case (in_reg.opcode)
                OP_TICK:
                begin
                    shown_conn_next[p] = live_conn_reg[p];
                    for (int c = 0; c < CONTROLS; c++)
                    begin
                        shown_next[p][c] = live_reg[p][c];
                        live_next[p][c]  = age_count(live_reg[p][c]);
                    end
                end
                OP_CONNECT:
                begin
                    if (pad_ok && int'(in_reg.pad) == p)
                    begin
                        live_conn_next[p] = in_reg.level;
                        if (!in_reg.level)
                        begin
                            shown_conn_next[p] = 1'b0;
                            for (int c = 0; c < CONTROLS; c++)
                            begin
                                live_next[p][c]  = CNT_MIN;
                                shown_next[p][c] = CNT_MIN;
                            end
                        end
                    end
                end
                OP_CONTROL:
                begin
                    if (take_event && int'(in_reg.pad) == p)
                    begin
                        for (int c = 0; c < CONTROLS; c++)
                        begin
                            if (int'(in_reg.control) == c)
                            begin
                                live_next[p][c] = in_reg.level ? cnt_t'(1) : cnt_t'(-1);
                            end
                            else if (in_reg.level && int'(in_reg.control) < DIRECTIONS
                                     && int'(opp) == c && live_reg[p][c] > 0)
                            begin
                                // Pressing a direction releases its opposite.
                                live_next[p][c] = cnt_t'(-1);
                            end
                        end
                    end
                end
                default:
                begin
                    live_conn_next[p] = live_conn_reg[p];
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg <= '0;
            for (int p = 0; p < PADS; p++)
            begin
                live_conn_reg[p]  <= 1'b0;
                shown_conn_reg[p] <= 1'b0;
                for (int c = 0; c < CONTROLS; c++)
                begin
                    live_reg[p][c]  <= CNT_MIN;
                    shown_reg[p][c] <= CNT_MIN;
                end
            end
        end
        else if (advance)
        begin
            sel_reg <= sel_next;
            for (int p = 0; p < PADS; p++)
            begin
                live_conn_reg[p]  <= live_conn_next[p];
                shown_conn_reg[p] <= shown_conn_next[p];
                for (int c = 0; c < CONTROLS; c++)
                begin
                    live_reg[p][c]  <= live_next[p][c];
                    shown_reg[p][c] <= shown_next[p][c];
                end
            end
        end
    end

    // The selection never points past the last pad.
    `GPTC_ASSERT_ALWAYS(a_sel_in_range, int'(sel_reg) < PADS)
    // A rejected bus access never carries data.
    `GPTC_ASSERT_SAME(a_status_no_data, rsp_valid && rsp.status, rsp.read_data == 13'sd0)
    // State only changes when an item is processed.
    `GPTC_ASSERT_NEXT(a_state_holds, !advance, $stable(sel_reg) && $stable(live_conn_reg[0]))

endmodule

`default_nettype wire
